>>> rtl/rsti64_pkg.sv
`timescale 1ns / 1ps

package rsti64_pkg;

	typedef enum logic [1:0] {
		MODE_DEC = 2'd0,
		MODE_HEX = 2'd1,
		MODE_OCT = 2'd2,
		MODE_BIN = 2'd3
	} radix_mode_t;

	typedef enum logic [2:0] {
		PH_LWS        = 3'd0,
		PH_AFTER_SIGN = 3'd1,
		PH_LZ         = 3'd2,
		PH_DIG        = 3'd3,
		PH_TWS        = 3'd4,
		PH_DONE       = 3'd5
	} parse_phase_t;

	localparam int unsigned MAX_LEN  = 65535;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned CNT_CAP_I = (MAX_LEN < 65535) ? MAX_LEN : 65535;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_CAP_I[CNT_W-1:0];

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [4:0] DIGIT_NONE = 5'd16;

	localparam logic [6:0] LIM_HEX = 7'd16;
	localparam logic [6:0] LIM_OCT = 7'd21;
	localparam logic [6:0] LIM_BIN = 7'd63;
	localparam logic [6:0] DCNT_MAX = 7'd127;

	// int64 limits and their decimal split (both limits share the same quotient)
	localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] DEC_QUOT  = 64'd922337203685477580;
	localparam logic [4:0]  POS_REM   = 5'd7;
	localparam logic [4:0]  NEG_REM   = 5'd8;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// digit value in the given radix, DIGIT_NONE if not a digit of it
	function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_mode_t mode);
		logic [7:0] v;
		v = {3'b0, DIGIT_NONE};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = c - CH_LA + 8'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			v = c - CH_UA + 8'd10;
		end
		case (mode)
			MODE_DEC: if (v > 8'd9) v = {3'b0, DIGIT_NONE};
			MODE_OCT: if (v > 8'd7) v = {3'b0, DIGIT_NONE};
			MODE_BIN: if (v > 8'd1) v = {3'b0, DIGIT_NONE};
			default: ;
		endcase
		return v[4:0];
	endfunction

endpackage

>>> rtl/radix_string_to_int64.sv
`timescale 1ns / 1ps

// radix_string_to_int64: streaming string to signed 64-bit integer parser
//
// s_* channel: one string byte per item in s_tdata, s_tlast on the final byte.
// m_* channel: one result item per string, sent after its final byte.
//   m_tdata holds the value and the consumed byte count, m_tuser the status
//   (1 when a byte was rejected).
// cfg_we / cfg_wdata: writes the radix mode (decimal, hex, octal, binary);
//   change it only between strings.
//
// throughput: one byte per cycle while no final byte waits on a full result
// register, set by the combinational parse/accumulate step that sits between
// the input register and the parse state registers.
// result path: the final byte waits in the input register, then the result register loads.
// stall: a result waiting in the result register does not block the input;
//   non-final bytes keep flowing, and only a second final byte waits in the
//   input register until the pending result is taken.
// reset: arst_n clears the parse state, empties both registers and sets the
//   radix to decimal.

module radix_string_to_int64
	import rsti64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,   // radix_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] char_byte
	input  logic        s_tlast,     // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,     // [63:0] result_value, [79:64] consumed_count
	output logic        m_tuser      // status
);

	radix_mode_t  mode_q;

	// input register
	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;

	// parse state
	parse_phase_t phase_q;
	logic         neg_q;
	logic [63:0]  acc_q;
	logic [6:0]   dcnt_q;
	logic         ovf_q;
	logic         zas_q;
	logic [15:0]  bcnt_q;

	// result register
	logic         out_valid_q;
	logic [63:0]  out_value_q;
	logic [15:0]  out_count_q;
	logic         out_status_q;

	logic         adv;

	// next parse state
	parse_phase_t ph_n;
	logic         neg_n;
	logic [63:0]  acc_n;
	logic [6:0]   dcnt_n;
	logic         ovf_n;
	logic         zas_n;
	logic [15:0]  bcnt_n;
	logic         consumed;
	logic [63:0]  res_value;

	// the item in s1 moves on unless it is a final byte and the result slot is full
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DEC;
		end else if (cfg_we) begin
			mode_q <= radix_mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// one byte of the grammar per cycle; each stage falls through to the next
	// when the byte does not belong to it
	always_comb begin
		logic        handled;
		logic        pre;
		logic [4:0]  d;
		logic [4:0]  rem;
		logic [6:0]  lim;
		logic [63:0] dec_next;

		ph_n     = phase_q;
		neg_n    = neg_q;
		acc_n    = acc_q;
		dcnt_n   = dcnt_q;
		ovf_n    = ovf_q;
		zas_n    = zas_q;
		consumed = 1'b0;
		handled  = 1'b0;
		pre      = 1'b0;
		d        = digit_of(char_s1, mode_q);
		rem      = neg_q ? NEG_REM : POS_REM;
		dec_next = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {59'd0, d};

		case (mode_q)
			MODE_HEX: lim = LIM_HEX;
			MODE_OCT: lim = LIM_OCT;
			default:  lim = LIM_BIN;
		endcase

		if (ph_n == PH_DONE) begin
			handled = 1'b1;
		end

		if (!handled && ph_n == PH_LWS) begin
			if (is_space(char_s1)) begin
				consumed = 1'b1;
				handled  = 1'b1;
			end else begin
				ph_n = PH_AFTER_SIGN;
				if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
					neg_n    = (char_s1 == CH_MINUS);
					consumed = 1'b1;
					handled  = 1'b1;
				end
			end
		end

		if (!handled && ph_n == PH_AFTER_SIGN) begin
			ph_n = PH_LZ;
			if (char_s1 == CH_ZERO) begin
				// this zero may open a 0x / 0b prefix
				zas_n    = (mode_q == MODE_HEX) || (mode_q == MODE_BIN);
				consumed = 1'b1;
				handled  = 1'b1;
			end
		end

		if (!handled && ph_n == PH_LZ) begin
			// prefix only when another byte follows it
			pre = zas_n && !last_s1 &&
			      ((mode_q == MODE_HEX && (char_s1 | CASE_BIT) == CH_LX) ||
			       (mode_q == MODE_BIN && (char_s1 | CASE_BIT) == CH_LB));
			zas_n = 1'b0;
			if (pre || char_s1 == CH_ZERO) begin
				consumed = 1'b1;
				handled  = 1'b1;
			end else begin
				ph_n = PH_DIG;
			end
		end

		if (!handled && ph_n == PH_DIG) begin
			if (d != DIGIT_NONE) begin
				if (mode_q == MODE_DEC) begin
					// saturating: digits past the limit are consumed but dropped
					if (acc_q > DEC_QUOT || (acc_q == DEC_QUOT && d > rem)) begin
						ovf_n = 1'b1;
					end else begin
						acc_n = dec_next;
					end
					if (dcnt_q < DCNT_MAX) begin
						dcnt_n = dcnt_q + 7'd1;
					end
					consumed = 1'b1;
					handled  = 1'b1;
				end else if (dcnt_q < lim) begin
					case (mode_q)
						MODE_HEX: acc_n = {acc_q[59:0], 4'b0} + {59'd0, d};
						MODE_OCT: acc_n = {acc_q[60:0], 3'b0} + {59'd0, d};
						default:  acc_n = {acc_q[62:0], 1'b0} + {59'd0, d};
					endcase
					dcnt_n   = dcnt_q + 7'd1;
					consumed = 1'b1;
					handled  = 1'b1;
				end
			end
			if (!handled) begin
				ph_n = PH_TWS;
			end
		end

		if (!handled) begin
			if (is_space(char_s1)) begin
				consumed = 1'b1;
			end else begin
				ph_n = PH_DONE;
			end
		end

		bcnt_n = (consumed && bcnt_q < CNT_CAP) ? bcnt_q + 16'd1 : bcnt_q;

		if (mode_q == MODE_DEC && ovf_n) begin
			res_value = neg_n ? NEG_LIMIT : POS_LIMIT;
		end else begin
			res_value = acc_n;
		end
		if (neg_n) begin
			res_value = 64'd0 - res_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LWS;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			dcnt_q  <= '0;
			ovf_q   <= 1'b0;
			zas_q   <= 1'b0;
			bcnt_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				// string finished: back to the start of the grammar
				phase_q <= PH_LWS;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				dcnt_q  <= '0;
				ovf_q   <= 1'b0;
				zas_q   <= 1'b0;
				bcnt_q  <= '0;
			end else begin
				phase_q <= ph_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				dcnt_q  <= dcnt_n;
				ovf_q   <= ovf_n;
				zas_q   <= zas_n;
				bcnt_q  <= bcnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_value_q  <= res_value;
			out_count_q  <= bcnt_n;
			out_status_q <= (ph_n == PH_DONE);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_value_q};
	assign m_tuser  = out_status_q;

	// a final byte never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !m_tready |=> valid_s1 && last_s1)
		else $error("final byte left s1 while result register was full");

	// the parse state starts over after every string
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == PH_LWS && bcnt_q == 16'd0 && acc_q == 64'd0)
		else $error("parse state not cleared after final byte");

	// once a byte is rejected nothing more is counted
	a_done_consumes_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && phase_q == PH_DONE |-> !consumed)
		else $error("byte consumed after rejection");

endmodule

>>> verif/radix_string_to_int64_test.sv
`timescale 1ns / 1ps

module radix_string_to_int64_test;
	import rsti64_pkg::*;

	// one parse result as it leaves the block
	typedef struct packed {
		logic [63:0] value;
		logic        status;
		logic [15:0] count;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] char_byte
	logic        s_tlast = 1'b0;   // is_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;          // [63:0] result_value, [79:64] consumed_count
	logic        m_tuser;          // status

	radix_string_to_int64 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("radix_string_to_int64_test failed");
		$finish;
	end

	// parse results predicted for accepted strings, oldest first
	parse_result_t due_results[$];
	int            fail_count = 0;
	bit            no_gaps = 1'b0;
	int            ready_hold = 0;
	logic [7:0]    str_q[$];

	// predicted parser state, mirrors the block between strings
	radix_mode_t   radix = MODE_DEC;
	parse_phase_t  ph = PH_LWS;
	logic          neg = 1'b0;
	logic [63:0]   acc = '0;
	int            ndig = 0;
	logic          ovf = 1'b0;
	logic          zpre = 1'b0;
	logic [15:0]   nbytes = '0;

	// idle length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int radix_base(input radix_mode_t m);
		case (m)
			MODE_DEC: return 10;
			MODE_HEX: return 16;
			MODE_OCT: return 8;
			default:  return 2;
		endcase
	endfunction

	// most digits accepted; decimal value only steers the generator
	function automatic int digit_cap(input radix_mode_t m);
		case (m)
			MODE_HEX: return LIM_HEX;
			MODE_OCT: return LIM_OCT;
			MODE_BIN: return LIM_BIN;
			default:  return 19;
		endcase
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// digit weight in radix m, 16 when c is no digit of it
	function automatic int digit_val(input logic [7:0] c, input radix_mode_t m);
		logic [7:0] lc;
		int v;
		lc = c | CASE_BIT;
		v = 16;
		if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
		else if (lc >= CH_LA && lc <= CH_LF) v = lc - CH_LA + 10;
		if (v >= radix_base(m)) v = 16;
		return v;
	endfunction

	function automatic void clear_parse_state();
		ph = PH_LWS;
		neg = 1'b0;
		acc = '0;
		ndig = 0;
		ovf = 1'b0;
		zpre = 1'b0;
		nbytes = '0;
	endfunction

	// advance the grammar by one byte; 1 when the byte is consumed
	function automatic logic take_byte(input logic [7:0] c, input logic fin);
		int d;
		logic [63:0] cut;
		logic pfx;
		if (ph == PH_DONE) return 1'b0;
		if (ph == PH_LWS) begin
			if (is_blank(c)) return 1'b1;
			ph = PH_AFTER_SIGN;
			if (c == CH_PLUS || c == CH_MINUS) begin
				neg = (c == CH_MINUS);
				return 1'b1;
			end
		end
		if (ph == PH_AFTER_SIGN) begin
			ph = PH_LZ;
			if (c == CH_ZERO) begin
				// a zero right after the sign may open a 0x or 0b prefix
				zpre = (radix == MODE_HEX || radix == MODE_BIN);
				return 1'b1;
			end
		end
		if (ph == PH_LZ) begin
			pfx = zpre && !fin &&
				((radix == MODE_HEX && (c | CASE_BIT) == CH_LX) ||
				 (radix == MODE_BIN && (c | CASE_BIT) == CH_LB));
			zpre = 1'b0;
			if (pfx || c == CH_ZERO) return 1'b1;
			ph = PH_DIG;
		end
		if (ph == PH_DIG) begin
			d = digit_val(c, radix);
			if (d < 16) begin
				if (radix == MODE_DEC) begin
					// saturate once the next digit would pass the int64 limit
					cut = neg ? NEG_LIMIT : POS_LIMIT;
					if (acc > cut / 10 || (acc == cut / 10 && d > cut % 10))
						ovf = 1'b1;
					else
						acc = acc * 10 + d;
					if (ndig < 127) ndig++;
					return 1'b1;
				end
				if (ndig < digit_cap(radix)) begin
					case (radix)
						MODE_HEX: acc = (acc << 4) + d;
						MODE_OCT: acc = (acc << 3) + d;
						default:  acc = (acc << 1) + d;
					endcase
					ndig++;
					return 1'b1;
				end
			end
			ph = PH_TWS;
		end
		if (is_blank(c)) return 1'b1;
		ph = PH_DONE;
		return 1'b0;
	endfunction

	// account one accepted byte; the final byte queues the expected result
	function automatic void parse_step(input logic [7:0] c, input logic fin);
		parse_result_t r;
		logic [63:0] mag;
		if (take_byte(c, fin) && nbytes < CNT_CAP) nbytes++;
		if (fin) begin
			mag = acc;
			if (radix == MODE_DEC && ovf) mag = neg ? NEG_LIMIT : POS_LIMIT;
			r.value = neg ? -mag : mag;
			r.status = (ph == PH_DONE);
			r.count = nbytes;
			due_results.push_back(r);
			clear_parse_state();
		end
	endfunction

	// one item on the input side, predicted at the edge that accepts it
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		do begin
			@(posedge clk);
		end while (!s_tready);
		parse_step(c, fin);
	endtask

	task automatic send_queued();
		foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
	endtask

	// lead, then n copies of ch, then tail, as one string
	task automatic send_padded(input string lead, input logic [7:0] ch, input int n,
			input string tail);
		str_q.delete();
		foreach (lead[i]) str_q.push_back(lead[i]);
		repeat (n) str_q.push_back(ch);
		foreach (tail[i]) str_q.push_back(tail[i]);
		send_queued();
	endtask

	task automatic send_str(input string s);
		send_padded(s, CH_SPACE, 0, "");
	endtask

	// stop sending, wait for every result, then cover the pipeline latency
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_radix(input radix_mode_t m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix = m;
	endtask

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
	endfunction

	function automatic logic [7:0] digit_char(input radix_mode_t m);
		int v;
		logic [7:0] ch;
		v = $urandom_range(0, radix_base(m) - 1);
		ch = (v < 10) ? 8'(CH_ZERO + v) : 8'(CH_LA + v - 10);
		if (v >= 10 && $urandom_range(0, 1)) ch = ch & ~CASE_BIT;
		return ch;
	endfunction

	// mostly well-formed numbers, some with a stray byte, a few pure noise
	task automatic build_random_string();
		int kind;
		int n;
		int lim;
		str_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) str_q.push_back(blank_char());
		case ($urandom_range(0, 3))
			0: str_q.push_back(CH_PLUS);
			1: str_q.push_back(CH_MINUS);
			default: ;
		endcase
		if ((radix == MODE_HEX || radix == MODE_BIN) && $urandom_range(0, 1)) begin
			str_q.push_back(CH_ZERO);
			str_q.push_back(((radix == MODE_HEX) ? CH_LX : CH_LB) &
				($urandom_range(0, 1) ? 8'hff : ~CASE_BIT));
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) str_q.push_back(CH_ZERO);
		lim = digit_cap(radix);
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(lim - 2, lim + 1) : $urandom_range(1, 8);
		repeat (n) str_q.push_back(digit_char(radix));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) str_q.push_back(blank_char());
		if (kind < 25)
			str_q.insert($urandom_range(0, str_q.size()), 8'($urandom_range(0, 255)));
		if (str_q.size() == 0) str_q.push_back(digit_char(radix));
	endtask

	// decimal: limits, saturation both ways, blanks, sign-only, rejects
	task automatic test_decimal_strings();
		set_radix(MODE_DEC);
		send_str("0");
		send_str("9223372036854775807");
		send_str("-9223372036854775808");
		send_str("9223372036854775808");
		send_str("-99999999999999999999999");
		send_str(" +42 \t");
		send_str("12a3");
		send_str("-");
		send_str("+-1");
		for (int c = CH_TAB; c <= CH_CR; c++) send_byte(8'(c), 1'b0);
		send_byte(CH_SPACE, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	// hex: prefix on and off the last byte, wrap, digit limit, leading zeros
	task automatic test_hex_strings();
		set_radix(MODE_HEX);
		send_str("0x");
		send_str("0xFFFFFFFFFFFFFFFF");
		send_str("-0X8000000000000000");
		send_str("0XaBcD");
		send_str("0xg");
		send_str("00x1");
		send_str("12345678901234567");
		send_padded("-", CH_ZERO, 22, "ff");
	endtask

	// octal: no prefix, the 21-digit limit, the 22nd digit rejected
	task automatic test_octal_strings();
		set_radix(MODE_OCT);
		send_str("0x1");
		send_str("8");
		send_padded("", "7", 21, "");
		send_padded("-", "7", 22, "");
	endtask

	// binary: prefix at the end, 63-digit limit, non-binary digit
	task automatic test_binary_strings();
		set_radix(MODE_BIN);
		send_str("0b");
		send_str("0B1");
		send_str("2");
		send_padded("0b", "1", 64, "");
	endtask

	task automatic test_random_strings();
		int sent;
		sent = 0;
		for (int p = 0; p < 8; p++) begin
			set_radix(radix_mode_t'((p < 4) ? p : $urandom_range(0, 3)));
			// one phase runs back to back on both the input and the result side
			no_gaps = (p == 5);
			while (sent < (p + 1) * 24) begin
				build_random_string();
				send_queued();
				sent += str_q.size();
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_decimal_strings();
		test_hex_strings();
		test_octal_strings();
		test_binary_strings();
		test_random_strings();
		settle();
		if (fail_count == 0) begin
			$display("radix_string_to_int64_test passed");
		end else begin
			$display("radix_string_to_int64_test failed");
		end
		$finish;
	end

	// result side back-pressure
	always @(posedge clk) begin : ready_ctl
		int g;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 1'b0;
		end else begin
			g = pick_gap();
			m_tready <= (g == 0);
			ready_hold <= (g > 0) ? g - 1 : 0;
		end
	end

	// compare each delivered result with the oldest prediction
	always @(posedge clk) begin : result_check
		parse_result_t want;
		if (m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$error("result item with nothing expected: value %0d",
					$signed(m_tdata[63:0]));
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (m_tdata[63:0] !== want.value) begin
					$error("result_value: expected %0d, got %0d",
						$signed(want.value), $signed(m_tdata[63:0]));
					fail_count++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					fail_count++;
				end
				if (m_tdata[79:64] !== want.count) begin
					$error("consumed_count: expected %0d, got %0d",
						want.count, m_tdata[79:64]);
					fail_count++;
				end
			end
		end
	end

endmodule
